/* hw/rtl/pbar_pkg.sv */
// ----------------------------------------------------------------------------
// pbar_pkg - physical bus access router shared definitions
// Target codes, register indexes, reset values and the queued part record.
// ----------------------------------------------------------------------------
package pbar_pkg;

  // target codes
  localparam logic [2:0] TGT_RAM   = 3'd0;
  localparam logic [2:0] TGT_ROM   = 3'd1;
  localparam logic [2:0] TGT_IO    = 3'd2;
  localparam logic [2:0] TGT_SUPER = 3'd3;
  localparam logic [2:0] TGT_STD   = 3'd4;
  localparam logic [2:0] TGT_MODEL = 3'd5;
  localparam logic [2:0] TGT_NONE  = 3'd6;

  // access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_WORD = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;
  localparam logic [1:0] SZ_LINE = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_SIZE_LOG2     = 2'd0;
  localparam logic [1:0] CFG_SYS_IDENT         = 2'd1;
  localparam logic [1:0] CFG_SLOT_PRESENT_MASK = 2'd2;

  localparam logic [4:0] ROM_SIZE_LOG2_RESET = 5'd20;
  localparam logic [4:0] ROM_SIZE_LOG2_MIN   = 5'd12;
  localparam logic [4:0] ROM_SIZE_LOG2_MAX   = 5'd28;

  localparam logic [31:0] SYS_IDENT_ADDR   = 32'h5fff_fffc;
  localparam logic [27:0] SYS_IDENT_OFFSET = 28'hfff_fffc;

  localparam int NUBUS_SLOTS_DEFAULT = 6;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [4:0]  rom_size_log2;
    logic [31:0] sys_ident;
    logic [5:0]  slot_present_mask;
  } pbar_cfg_t;

  // one routed part as handed from the front to the back
  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  size;
    logic        wr;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        line_direct;  // aligned line, goes to RAM unrouted
    logic        not_first;
    logic        part_last;
    logic [31:0] orig_addr;
    logic [4:0]  transfer_type;
    logic [1:0]  access_size;
    logic        fetch;
  } pbar_part_t;

endpackage

/* hw/rtl/pbar_req_if.sv */
// ----------------------------------------------------------------------------
// pbar_req_if - bus access request channel
// Valid/ready channel carrying one physical bus access.
// ----------------------------------------------------------------------------
interface pbar_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] address;
  logic [1:0]  access_size;
  logic [4:0]  transfer_type;
  logic        is_instruction;
  logic [63:0] write_data_low;
  logic [63:0] write_data_high;

  modport source (
    output valid, req_type, address, access_size, transfer_type, is_instruction,
           write_data_low, write_data_high,
    input  ready
  );

  modport sink (
    input  valid, req_type, address, access_size, transfer_type, is_instruction,
           write_data_low, write_data_high,
    output ready
  );
endinterface

/* hw/rtl/pbar_rsp_if.sv */
// ----------------------------------------------------------------------------
// pbar_rsp_if - routed sub-access channel
// Valid/ready channel carrying one routed sub-access or fault status.
// ----------------------------------------------------------------------------
interface pbar_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [2:0]  slot_index;
  logic [31:0] local_address;
  logic [1:0]  sub_size;
  logic        sub_is_write;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic        fault;
  logic [31:0] fault_address;
  logic [11:0] status_word;
  logic        fault_on_fetch;
  logic        last;

  modport source (
    output valid, target, slot_index, local_address, sub_size, sub_is_write,
           data_low, data_high, fault, fault_address, status_word,
           fault_on_fetch, last,
    input  ready
  );

  modport sink (
    input  valid, target, slot_index, local_address, sub_size, sub_is_write,
           data_low, data_high, fault, fault_address, status_word,
           fault_on_fetch, last,
    output ready
  );
endinterface

/* hw/rtl/pbar_front.sv */
// ----------------------------------------------------------------------------
// pbar_front - request intake and splitter
// Holds one request and pushes its aligned parts into the queue, one a cycle unless it is full.
// ----------------------------------------------------------------------------
module pbar_front (
  input  logic               clk,
  input  logic               rst,
  pbar_req_if.sink           req,
  output logic               part_valid,
  output pbar_pkg::pbar_part_t part,
  input  logic               queue_full
);

  logic        busy;
  logic [3:0]  k;
  logic        wr;
  logic [31:0] addr;
  logic [1:0]  sz;
  logic [4:0]  tt;
  logic        fetch;
  logic [63:0] dl;
  logic [63:0] dh;

  logic         line_direct;
  logic         byte_split;
  logic         word_split;
  logic [3:0]   last_k;
  logic [3:0]   byte_idx;
  logic [4:0]   part_off;
  logic [127:0] line_data;
  logic [7:0]   sel_byte;
  logic         push;
  logic         push_last;

  always_comb begin
    line_direct = (sz == pbar_pkg::SZ_LINE) && (addr[3:0] == 4'd0);
    byte_split  = ((sz == pbar_pkg::SZ_WORD) && addr[0]) ||
                  ((sz == pbar_pkg::SZ_LONG) && addr[0]) ||
                  ((sz == pbar_pkg::SZ_LINE) && !line_direct);
    word_split  = (sz == pbar_pkg::SZ_LONG) && !addr[0] && addr[1];

    if (byte_split) begin
      case (sz)
        pbar_pkg::SZ_WORD: last_k = 4'd1;
        pbar_pkg::SZ_LONG: last_k = 4'd3;
        default:           last_k = 4'd15;
      endcase
    end else if (word_split) begin
      last_k = 4'd1;
    end else begin
      last_k = 4'd0;
    end

    // byte splits of words and longs go most significant byte first
    case (sz)
      pbar_pkg::SZ_WORD: byte_idx = 4'd1 - k;
      pbar_pkg::SZ_LONG: byte_idx = 4'd3 - k;
      default:           byte_idx = k;
    endcase
    line_data = {dh, dl};
    sel_byte  = line_data[{byte_idx, 3'b000} +: 8];
    part_off  = word_split ? {k, 1'b0} : {1'b0, k};

    part             = '0;
    part.addr        = addr + {27'd0, part_off};
    part.wr          = wr;
    part.line_direct = line_direct;
    part.not_first   = (k != 4'd0);
    part.part_last   = (k == last_k);
    part.orig_addr   = addr;
    part.transfer_type = tt;
    part.access_size = sz;
    part.fetch       = fetch;
    if (line_direct) begin
      part.size      = pbar_pkg::SZ_LINE;
      part.data_low  = dl;
      part.data_high = dh;
    end else if (byte_split) begin
      part.size      = pbar_pkg::SZ_BYTE;
      part.data_low  = {56'd0, sel_byte};
    end else if (word_split) begin
      part.size      = pbar_pkg::SZ_WORD;
      part.data_low  = (k == 4'd0) ? {48'd0, dl[31:16]} : {48'd0, dl[15:0]};
    end else begin
      part.size = sz;
      case (sz)
        pbar_pkg::SZ_BYTE: part.data_low = {56'd0, dl[7:0]};
        pbar_pkg::SZ_WORD: part.data_low = {48'd0, dl[15:0]};
        default:           part.data_low = {32'd0, dl[31:0]};
      endcase
    end
  end

  assign push       = busy && !queue_full;
  assign push_last  = push && (k == last_k);
  assign part_valid = push;
  assign req.ready  = !busy || push_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 4'd0;
    end else begin
      if (req.valid && req.ready) begin
        busy <= 1'b1;
        k    <= 4'd0;
      end else if (push_last) begin
        busy <= 1'b0;
      end else if (push) begin
        k <= k + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      wr    <= req.req_type;
      addr  <= req.address;
      sz    <= req.access_size;
      tt    <= req.transfer_type;
      fetch <= req.is_instruction;
      dl    <= req.write_data_low;
      dh    <= req.write_data_high;
    end
  end

endmodule

/* hw/rtl/pbar_fifo.sv */
// ----------------------------------------------------------------------------
// pbar_fifo - part queue
// Small register queue between the splitter and the router.
// ----------------------------------------------------------------------------
module pbar_fifo #(
  parameter int DEPTH = pbar_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pbar_pkg::pbar_part_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output pbar_pkg::pbar_part_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  pbar_pkg::pbar_part_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == CW'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* hw/rtl/pbar_back.sv */
// ----------------------------------------------------------------------------
// pbar_back - part router
// Decodes each queued part to a target, tracks the ROM overlay and faults.
// ----------------------------------------------------------------------------
module pbar_back #(
  parameter int NUBUS_SLOTS = pbar_pkg::NUBUS_SLOTS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pbar_pkg::pbar_cfg_t  cfg,
  input  logic                 part_valid,
  input  pbar_pkg::pbar_part_t part,
  output logic                 part_pop,
  pbar_rsp_if.source           rsp
);

  logic rom_overlay;
  logic skip;          // dropping the rest of a faulted request
  logic out_valid;

  logic [3:0]  nib;
  logic [3:0]  std_slot;
  logic [4:0]  rom_n;
  logic [31:0] rom_mask;
  logic [2:0]  tgt;
  logic [2:0]  slot;
  logic [31:0] loc;
  logic [63:0] dlo;
  logic [63:0] dhi;
  logic        flt;
  logic        clear_overlay;
  logic        take;
  logic        route_now;

  function automatic logic slot_ok(input logic [2:0] s, input logic [5:0] mask);
    slot_ok = (int'(s) < NUBUS_SLOTS) && (s < 3'd6) && mask[s];
  endfunction

  always_comb begin
    nib      = part.addr[31:28];
    std_slot = part.addr[27:24];
    if (cfg.rom_size_log2 < pbar_pkg::ROM_SIZE_LOG2_MIN) begin
      rom_n = pbar_pkg::ROM_SIZE_LOG2_MIN;
    end else if (cfg.rom_size_log2 > pbar_pkg::ROM_SIZE_LOG2_MAX) begin
      rom_n = pbar_pkg::ROM_SIZE_LOG2_MAX;
    end else begin
      rom_n = cfg.rom_size_log2;
    end
    rom_mask = (32'd1 << rom_n) - 32'd1;

    tgt           = pbar_pkg::TGT_RAM;
    slot          = 3'd0;
    loc           = part.addr;
    dlo           = part.wr ? part.data_low : 64'd0;
    dhi           = 64'd0;
    flt           = 1'b0;
    clear_overlay = 1'b0;

    if (part.line_direct) begin
      dhi = part.wr ? part.data_high : 64'd0;
    end else begin
      case (nib)
        4'd0: begin
          if (rom_overlay) begin
            flt = part.wr;
            tgt = pbar_pkg::TGT_ROM;
            loc = part.addr & rom_mask;
          end
        end
        4'd1, 4'd2, 4'd3: begin
          tgt = pbar_pkg::TGT_RAM;
        end
        4'd4: begin
          clear_overlay = 1'b1;
          flt = part.wr;
          tgt = pbar_pkg::TGT_ROM;
          loc = part.addr & rom_mask;
        end
        4'd5: begin
          if (part.size == pbar_pkg::SZ_LONG && !part.wr &&
              part.addr[27:0] == pbar_pkg::SYS_IDENT_OFFSET) begin
            tgt = pbar_pkg::TGT_MODEL;
            dlo = {32'd0, cfg.sys_ident};
          end else if (part.size == pbar_pkg::SZ_LONG && part.wr &&
                       part.addr == pbar_pkg::SYS_IDENT_ADDR &&
                       (part.data_low[31:0] == 32'd0 ||
                        part.data_low[31:0] == 32'hffff_ffff)) begin
            // write of 0 or all ones to the ident address is dropped
            tgt = pbar_pkg::TGT_NONE;
            loc = 32'd0;
            dlo = 64'd0;
          end else begin
            tgt = pbar_pkg::TGT_IO;
          end
        end
        4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14: begin
          slot = 3'(nib - 4'd9);
          flt  = !slot_ok(slot, cfg.slot_present_mask);
          tgt  = pbar_pkg::TGT_SUPER;
          loc  = {4'd0, part.addr[27:0]};
        end
        4'd15: begin
          slot = 3'(std_slot - 4'd9);
          flt  = !(std_slot inside {[4'd9:4'd14]}) ||
                 !slot_ok(slot, cfg.slot_present_mask);
          tgt  = pbar_pkg::TGT_STD;
          loc  = {8'd0, part.addr[23:0]};
        end
        default: begin
          flt = 1'b1;
        end
      endcase
    end
  end

  assign take      = !out_valid || rsp.ready;
  assign part_pop  = part_valid && (take || skip);
  assign route_now = part_pop && !skip;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_overlay <= 1'b1;
      skip        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (route_now) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (part_pop && skip) begin
        skip <= !part.part_last;
      end else if (route_now && flt) begin
        skip <= !part.part_last;
      end
      if (route_now && clear_overlay) begin
        rom_overlay <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (route_now) begin
      rsp.sub_size     <= part.size;
      rsp.sub_is_write <= part.wr;
      rsp.data_high    <= flt ? 64'd0 : dhi;
      if (flt) begin
        rsp.target         <= pbar_pkg::TGT_NONE;
        rsp.slot_index     <= 3'd0;
        rsp.local_address  <= 32'd0;
        rsp.data_low       <= 64'd0;
        rsp.fault          <= 1'b1;
        rsp.fault_address  <= part.orig_addr;
        rsp.status_word    <= {part.not_first, 2'b00, part.wr, 1'b0,
                               part.access_size, part.transfer_type};
        rsp.fault_on_fetch <= part.fetch;
        rsp.last           <= 1'b1;
      end else begin
        rsp.target         <= tgt;
        rsp.slot_index     <= slot;
        rsp.local_address  <= loc;
        rsp.data_low       <= dlo;
        rsp.fault          <= 1'b0;
        rsp.fault_address  <= 32'd0;
        rsp.status_word    <= 12'd0;
        rsp.fault_on_fetch <= 1'b0;
        rsp.last           <= part.part_last;
      end
    end
  end

endmodule

/* hw/rtl/physical_bus_access_router.sv */
// ----------------------------------------------------------------------------
// physical_bus_access_router - physical bus access router top level
//
//   channel  dir  handshake     contents
//   req      in   valid/ready   one bus access (read/write, size, data)
//   rsp      out  valid/ready   one routed sub-access or fault per part
//   cfg_*    in   write enable  rom_size_log2, sys_ident, slot_present_mask
//
// A request splits into 1, 2, 4 or 16 parts; the splitter issues one part a
// cycle while the queue is not full and holds the input until its last part
// is pushed; results leave at one per cycle while rsp is ready.
// A fault drops the remaining parts of its request in the router.
// rsp stalls back up through the part queue into the splitter.
// Reset: overlay set, ROM size 2^20, ident 0, no slots present.
// ----------------------------------------------------------------------------
module physical_bus_access_router #(
  parameter int NUBUS_SLOTS = pbar_pkg::NUBUS_SLOTS_DEFAULT,
  parameter int QUEUE_DEPTH = pbar_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pbar_req_if.sink    req,
  pbar_rsp_if.source  rsp
);

  pbar_pkg::pbar_cfg_t  cfg;
  pbar_pkg::pbar_part_t front_part;
  pbar_pkg::pbar_part_t back_part;
  logic front_valid;
  logic queue_full;
  logic back_valid;
  logic back_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rom_size_log2     <= pbar_pkg::ROM_SIZE_LOG2_RESET;
      cfg.sys_ident         <= 32'd0;
      cfg.slot_present_mask <= 6'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbar_pkg::CFG_ROM_SIZE_LOG2:     cfg.rom_size_log2     <= cfg_data[4:0];
        pbar_pkg::CFG_SYS_IDENT:         cfg.sys_ident         <= cfg_data;
        pbar_pkg::CFG_SLOT_PRESENT_MASK: cfg.slot_present_mask <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  pbar_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .part_valid (front_valid),
    .part       (front_part),
    .queue_full (queue_full)
  );

  pbar_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .push_data (front_part),
    .full      (queue_full),
    .pop       (back_pop),
    .pop_valid (back_valid),
    .pop_data  (back_part)
  );

  pbar_back #(
    .NUBUS_SLOTS (NUBUS_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .part_valid (back_valid),
    .part       (back_part),
    .part_pop   (back_pop),
    .rsp        (rsp)
  );

endmodule
